// File: src/hlrf_search_direction_macros.svh
// Assertion macros shared by the search direction block.
`ifndef HLRF_SEARCH_DIRECTION_MACROS_SVH
`define HLRF_SEARCH_DIRECTION_MACROS_SVH

// Same-cycle implication, disabled during reset
`define HLRF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hlrf: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define HLRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hlrf: next-cycle check failed");

`endif

// File: src/hlrf_pkg.sv
// Types and constants of the search direction block.
`default_nettype none
package hlrf_pkg;
    localparam int MAX_LENGTH = 32;
    localparam int IDX_W      = $clog2(MAX_LENGTH);
    localparam int CNT_W      = 6;
    localparam int DATA_W     = 32;
    localparam int QBITS      = 35;

    localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_ZERO_NORM = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_DOT,
        ST_ACC,
        ST_EMAG,
        ST_RD,
        ST_LAT,
        ST_MLO,
        ST_MHI,
        ST_SUMP,
        ST_CMP,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } t_state;
endpackage
`default_nettype wire

// File: src/hlrf_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module hlrf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: src/hlrf_search_direction.sv
// HLRF search direction: element loader, shared multiplier and serial divider.
//
// Usage:
//   s_axis carries one element per transaction: u_i, grad_i and g (g is used
//   from the final element of a run). vector_length is written on the cfg
//   channel (always ready); it must be written only while the block is idle, which
//   the block does not enforce; 0 acts as 1, values above 32 act as 32.
//   Loading an element: one 33x33 multiplier forms grad^2 and grad*u in turn,
//   then both saturating 64-bit sums are updated.
//   After the final element, each result takes a RAM read, two passes through
//   the same multiplier for |e|*|grad_i| (96 bits), a range compare and, unless
//   that compare saturates the result, 35 steps of a restoring divider by
//   |grad|^2, one quotient bit per cycle; the first result also forms |e|.
//   Results leave on m_axis: tdata = d_i, tuser = status, tlast on the final
//   one. A zero gradient gives one result with status set and d = 0.
//   s_axis_tready is high only while idle; a stalled m_axis holds the result
//   register and the sequencer until the transaction completes.
//   Reset (synchronous, active low) clears counts and sums and sets the length
//   to 32; the element stores are not cleared, as a run reads only what it wrote.
`default_nettype none
`include "hlrf_search_direction_macros.svh"
module hlrf_search_direction import hlrf_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output      logic        o_cfg_ready,
    input  wire logic [5:0]  i_cfg_data,     // vector_length
    // input stream
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [95:0] s_axis_tdata,   // point_value, gradient_value, limit_value
    // result stream
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [31:0] m_axis_tdata,   // direction_value
    output      logic        m_axis_tuser,   // status
    output      logic        m_axis_tlast
);
    t_state r_state, n_state;

    logic [CNT_W-1:0]  r_vlen;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_cnt;
    logic [IDX_W-1:0]  r_k;
    logic signed [31:0] r_u, r_gr, r_limit;
    logic [63:0]       r_sq;
    logic signed [63:0] r_dot;
    logic signed [63:0] r_prod;
    logic [63:0]       r_emag;
    logic              r_eneg;
    logic [31:0]       r_gm;
    logic              r_gneg;
    logic signed [31:0] r_uk;
    logic [95:0]       r_acc;
    logic [QBITS-1:0]  r_low;
    logic [63:0]       r_rem;
    logic [QBITS-1:0]  r_q;
    logic [5:0]        r_bit;
    logic              r_big;
    logic [31:0]       r_dout;
    logic              r_status;
    logic              r_last;

    logic              in_fire, out_fire, run_end, last_elem, div_ge;
    logic [CNT_W-1:0]  eff_len, count_inc;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic [64:0]       sq_sum;
    logic signed [64:0] dot_sum;
    logic signed [64:0] diff;
    logic [64:0]       rem2;
    logic [64:0]       rem_sub;
    logic [31:0]       rd_u, rd_g;
    logic signed [36:0] q_signed, d_full;
    logic [31:0]       d_sat;

    assign in_fire   = s_axis_tvalid & s_axis_tready;
    assign out_fire  = m_axis_tvalid & m_axis_tready;
    assign count_inc = r_count + 6'd1;
    assign last_elem = ({1'b0, r_k} + 6'd1) == r_cnt;

    // effective run length
    always_comb begin
        if (r_vlen == 6'd0) begin
            eff_len = 6'd1;
        end else if (r_vlen > 6'(MAX_LENGTH)) begin
            eff_len = 6'(MAX_LENGTH);
        end else begin
            eff_len = r_vlen;
        end
    end
    assign run_end = count_inc >= eff_len;

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            ST_SQ:   begin mul_a = 33'(r_gr);            mul_b = 33'(r_gr); end
            ST_DOT:  begin mul_a = 33'(r_gr);            mul_b = 33'(r_u);  end
            ST_MLO:  begin mul_a = {1'b0, r_emag[31:0]};  mul_b = {1'b0, r_gm}; end
            ST_MHI:  begin mul_a = {1'b0, r_emag[63:32]}; mul_b = {1'b0, r_gm}; end
            default: begin mul_a = '0;                   mul_b = '0; end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // saturating accumulators
    assign sq_sum  = {1'b0, r_sq} + {1'b0, r_prod};
    assign dot_sum = {r_dot[63], r_dot} + {r_prod[63], r_prod};

    // error term dot - (g << 24)
    assign diff = {r_dot[63], r_dot} - {{9{r_limit[31]}}, r_limit, 24'd0};

    // one restoring division step
    assign rem2    = {r_rem, r_low[QBITS-1]};
    assign div_ge  = rem2 >= {1'b0, r_sq};
    assign rem_sub = rem2 - {1'b0, r_sq};

    // signed quotient minus u, saturated
    assign q_signed = (r_gneg ^ r_eneg) ? -$signed({2'b00, r_q}) : $signed({2'b00, r_q});
    assign d_full   = q_signed - 37'(r_uk);
    always_comb begin
        if (r_big) begin
            d_sat = (r_gneg ^ r_eneg) ? SAT_MIN : SAT_MAX;
        end else if (d_full > 37'sh0_7FFF_FFFF) begin
            d_sat = SAT_MAX;
        end else if (d_full < -37'sh0_8000_0000) begin
            d_sat = SAT_MIN;
        end else begin
            d_sat = d_full[31:0];
        end
    end

    // element stores
    hlrf_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LENGTH)) u_point_ram (
        .i_clk   (i_clk),
        .i_we    (in_fire),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (s_axis_tdata[31:0]),
        .i_raddr (r_k),
        .o_rdata (rd_u)
    );
    hlrf_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LENGTH)) u_grad_ram (
        .i_clk   (i_clk),
        .i_we    (in_fire),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (s_axis_tdata[63:32]),
        .i_raddr (r_k),
        .o_rdata (rd_g)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (in_fire) n_state = ST_SQ;
            ST_SQ:   n_state = ST_DOT;
            ST_DOT:  n_state = ST_ACC;
            ST_ACC: begin
                if (!run_end) n_state = ST_IDLE;
                else if (r_sq == 64'd0) n_state = ST_OUT;
                else n_state = ST_EMAG;
            end
            ST_EMAG: n_state = ST_RD;
            ST_RD:   n_state = ST_LAT;
            ST_LAT:  n_state = ST_MLO;
            ST_MLO:  n_state = ST_MHI;
            ST_MHI:  n_state = ST_SUMP;
            ST_SUMP: n_state = ST_CMP;
            ST_CMP:  n_state = ({3'b000, r_acc} >= {r_sq, 35'd0}) ? ST_FIN : ST_DIV;
            ST_DIV:  if (r_bit == 6'd0) n_state = ST_FIN;
            ST_FIN:  n_state = ST_OUT;
            ST_OUT: begin
                if (out_fire) n_state = r_last ? ST_IDLE : ST_RD;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        m_axis_tvalid = (r_state == ST_OUT);
        o_cfg_ready   = 1'b1;
        m_axis_tdata  = r_dout;
        m_axis_tuser  = r_status;
        m_axis_tlast  = r_last;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_vlen  <= 6'(MAX_LENGTH);
            r_count <= '0;
            r_sq    <= '0;
            r_dot   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) r_vlen <= i_cfg_data;
            case (r_state)
                ST_DOT: r_sq <= sq_sum[64] ? '1 : sq_sum[63:0];
                ST_ACC: begin
                    if (dot_sum[64] != dot_sum[63]) begin
                        r_dot <= dot_sum[64] ? 64'sh8000_0000_0000_0000
                                             : 64'sh7FFF_FFFF_FFFF_FFFF;
                    end else begin
                        r_dot <= dot_sum[63:0];
                    end
                    r_count <= run_end ? '0 : count_inc;
                end
                ST_OUT: begin
                    if (out_fire && r_last) begin
                        r_sq  <= '0;
                        r_dot <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    r_u     <= s_axis_tdata[31:0];
                    r_gr    <= s_axis_tdata[63:32];
                    r_limit <= s_axis_tdata[95:64];
                end
            end
            ST_SQ:  r_prod <= mul_p[63:0];
            ST_DOT: r_prod <= mul_p[63:0];
            ST_ACC: begin
                r_cnt    <= count_inc;
                r_k      <= '0;
                r_dout   <= '0;
                r_status <= STATUS_ZERO_NORM;
                r_last   <= 1'b1;
            end
            ST_EMAG: begin
                r_eneg <= diff[64];
                r_emag <= diff[64] ? 64'(-diff) : diff[63:0];
            end
            ST_LAT: begin
                r_gneg <= rd_g[31];
                r_gm   <= rd_g[31] ? -rd_g : rd_g;
                r_uk   <= rd_u;
            end
            ST_MLO: r_prod <= mul_p[63:0];
            ST_MHI: begin
                r_acc  <= {32'd0, r_prod};
                r_prod <= mul_p[63:0];
            end
            ST_SUMP: r_acc <= r_acc + {r_prod, 32'd0};
            ST_CMP: begin
                r_big <= {3'b000, r_acc} >= {r_sq, 35'd0};
                r_rem <= {3'b000, r_acc[95:QBITS]};
                r_low <= r_acc[QBITS-1:0];
                r_q   <= '0;
                r_bit <= 6'(QBITS - 1);
            end
            ST_DIV: begin
                r_rem <= div_ge ? rem_sub[63:0] : rem2[63:0];
                r_q   <= {r_q[QBITS-2:0], div_ge};
                r_low <= {r_low[QBITS-2:0], 1'b0};
                r_bit <= r_bit - 6'd1;
            end
            ST_FIN: begin
                r_dout   <= d_sat;
                r_status <= STATUS_OK;
                r_last   <= last_elem;
            end
            ST_OUT: begin
                if (out_fire && !r_last) r_k <= r_k + 1'b1;
            end
            default: ;
        endcase
    end

    // checks
    `HLRF_ASSERT_IMPL(a_ready_excl, i_clk, i_rst_n, s_axis_tready, !m_axis_tvalid)
    `HLRF_ASSERT_IMPL(a_zero_norm, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tlast && (m_axis_tdata == 32'd0))
    `HLRF_ASSERT_NEXT(a_run_done, i_clk, i_rst_n, out_fire && m_axis_tlast, s_axis_tready)
    `HLRF_ASSERT_IMPL(a_count_range, i_clk, i_rst_n, 1'b1, r_count < 6'(MAX_LENGTH))
endmodule
`default_nettype wire
